/* rtl/spq_pkg.sv */
// shared types and codes for the sorted priority queue
package spq_pkg;

  // request codes
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] new_value;
    logic [15:0] new_priority;
  } req_t;

  typedef struct packed {
    logic [31:0] front_value;
    logic [15:0] front_priority;
    logic [4:0]  count;
    logic        is_empty;
    logic [1:0]  error_code;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       insert;
    logic       remove;
    logic       capture;
    logic [1:0] error_code;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_dequeue;
    logic full;
    logic empty;
  } status_t;

endpackage

/* rtl/sorted_priority_queue_unit.sv */
// top level of the sorted priority queue
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_ready  req (spq_pkg::req_t)
//   response  out        rsp_valid / rsp_ready  rsp (spq_pkg::rsp_t)
//
// an accepted request is latched, then inserted or removed across the shifting
// slot row while its response is captured, and the response is then held valid
// one request in flight; the next can be taken the cycle after the response is taken
// a stalled response holds its register and blocks new requests
// synchronous reset clears the entry count and the controller, slots need none
module sorted_priority_queue_unit #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  parameter int PRIO_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  // command and status between controller and slot row
  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t status;

  // sequencer: latch, execute, hold response
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // sorted slot row; slot 0 holds the smallest priority
  spq_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS),
    .PRIO_BITS  (PRIO_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

`ifndef SYNTH
  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while a response is pending");

  // an accepted request yields a response once it has passed the execute state
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> ##2 rsp_valid)
    else $error("response missing after accepted request");

  // an empty queue reports a zero front and never a full error
  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |->
      (rsp.front_value == '0 && rsp.front_priority == '0 &&
       rsp.error_code != spq_pkg::ERR_FULL))
    else $error("empty response carries a front entry");

  // insert and remove are never commanded together
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && cmd.remove))
    else $error("insert and remove in the same cycle");
`endif

endmodule

/* rtl/spq_ctrl.sv */
// control state machine of the sorted priority queue
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  spq_pkg::status_t   status,
  output spq_pkg::cmd_t      cmd
);

  spq_pkg::state_t state;
  spq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = spq_pkg::ST_EXEC;
        end
      end
      spq_pkg::ST_EXEC: begin
        state_next = spq_pkg::ST_DONE;
      end
      spq_pkg::ST_DONE: begin
        if (rsp_ready) begin
          state_next = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready      = 1'b0;
    rsp_valid      = 1'b0;
    cmd.load       = 1'b0;
    cmd.insert     = 1'b0;
    cmd.remove     = 1'b0;
    cmd.capture    = 1'b0;
    cmd.error_code = spq_pkg::ERR_OK;
    unique case (state)
      spq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      spq_pkg::ST_EXEC: begin
        cmd.capture = 1'b1;
        priority if (status.is_dequeue && status.empty) begin
          cmd.error_code = spq_pkg::ERR_EMPTY;
        end else if (status.is_dequeue) begin
          cmd.remove = 1'b1;
        end else if (status.full) begin
          cmd.error_code = spq_pkg::ERR_FULL;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      spq_pkg::ST_DONE: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/spq_datapath.sv */
// sorted slot row, entry count and response register
module spq_datapath #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  parameter int PRIO_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  spq_pkg::req_t    req,
  input  spq_pkg::cmd_t    cmd,
  output spq_pkg::status_t status,
  output spq_pkg::rsp_t    rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::req_t          req_q;
  logic [VALUE_BITS-1:0]  slot_value      [CAPACITY];
  logic [PRIO_BITS-1:0]   slot_priority   [CAPACITY];
  logic [VALUE_BITS-1:0]  slot_value_next [CAPACITY];
  logic [PRIO_BITS-1:0]   slot_priority_next [CAPACITY];
  logic [CAPACITY-1:0]    ahead;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [63:0]            val_wide;
  logic [31:0]            pri_wide;
  logic [VALUE_BITS-1:0]  new_val;
  logic [PRIO_BITS-1:0]   new_pri;
  logic [63:0]            front_val_wide;
  logic [31:0]            front_pri_wide;
  logic [31:0]            cnt_wide;
  spq_pkg::rsp_t          rsp_next;

  // fit the request fields to the stored widths
  always_comb begin
    val_wide = 64'(req_q.new_value);
    pri_wide = 32'(req_q.new_priority);
    new_val  = val_wide[VALUE_BITS-1:0];
    new_pri  = pri_wide[PRIO_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_slot
      // occupied slots that stay ahead of the new entry form a prefix
      assign ahead[gi] = (cnt > CNT_W'(gi)) && (slot_priority[gi] < new_pri);

      logic at_pos;
      if (gi == 0) begin : g_first
        assign at_pos = !ahead[gi];
      end else begin : g_rest
        assign at_pos = !ahead[gi] && ahead[gi-1];
      end

      logic [VALUE_BITS-1:0] up_val;
      logic [PRIO_BITS-1:0]  up_pri;
      logic [VALUE_BITS-1:0] down_val;
      logic [PRIO_BITS-1:0]  down_pri;
      if (gi == 0) begin : g_no_up
        assign up_val = slot_value[gi];
        assign up_pri = slot_priority[gi];
      end else begin : g_up
        assign up_val = slot_value[gi-1];
        assign up_pri = slot_priority[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_no_down
        assign down_val = slot_value[gi];
        assign down_pri = slot_priority[gi];
      end else begin : g_down
        assign down_val = slot_value[gi+1];
        assign down_pri = slot_priority[gi+1];
      end

      always_comb begin
        slot_value_next[gi]    = slot_value[gi];
        slot_priority_next[gi] = slot_priority[gi];
        priority if (cmd.insert && at_pos) begin
          slot_value_next[gi]    = new_val;
          slot_priority_next[gi] = new_pri;
        end else if (cmd.insert && !ahead[gi]) begin
          slot_value_next[gi]    = up_val;
          slot_priority_next[gi] = up_pri;
        end else if (cmd.remove) begin
          slot_value_next[gi]    = down_val;
          slot_priority_next[gi] = down_pri;
        end
      end

      always_ff @(posedge clk) begin
        slot_value[gi]    <= slot_value_next[gi];
        slot_priority[gi] <= slot_priority_next[gi];
      end
    end
  endgenerate

  always_comb begin
    cnt_next = cnt;
    if (cmd.insert) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (cmd.remove) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  assign status.is_dequeue = (req_q.req_type == spq_pkg::REQ_DEQUEUE);
  assign status.full       = (cnt == CNT_W'(CAPACITY));
  assign status.empty      = (cnt == '0);

  // response describes the queue after this operation
  always_comb begin
    front_val_wide = 64'(slot_value_next[0]);
    front_pri_wide = 32'(slot_priority_next[0]);
    cnt_wide       = 32'(cnt_next);
    rsp_next.count      = cnt_wide[4:0];
    rsp_next.error_code = cmd.error_code;
    if (cnt_next == '0) begin
      rsp_next.front_value    = '0;
      rsp_next.front_priority = '0;
      rsp_next.is_empty       = 1'b1;
    end else begin
      rsp_next.front_value    = front_val_wide[31:0];
      rsp_next.front_priority = front_pri_wide[15:0];
      rsp_next.is_empty       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* sim/tb.sv */
// testbench for the sorted priority queue: random and directed requests against a predictor
module tb;

  localparam int CAPACITY    = 16;
  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 500000;  // the slowest legal run stays well under this limit
  localparam int QUIET_TAIL  = 150;     // last requests go with no idling on either side
  localparam int HOLD_AT     = 600;     // requests taken before the long response hold
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 1200;    // sender waits for every response before this request
  localparam int TAIL_CYCLES = 10;      // margin after the last response is checked

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  spq_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  spq_pkg::rsp_t rsp_data;

  // request stream waiting to be offered, and responses owed by the block
  spq_pkg::req_t pending_reqs[$];
  spq_pkg::rsp_t expected_rsps[$];

  // predictor copy of the sorted slot row
  logic [31:0] slot_val [CAPACITY];
  logic [15:0] slot_pri [CAPACITY];
  int unsigned held = 0;

  // run statistics
  int n_enq = 0;
  int n_deq = 0;
  int n_full = 0;
  int n_empty = 0;
  int rsp_seen = 0;
  int mismatch_count = 0;

  // handshake bookkeeping of the driving processes and the monitor
  int offered_count = 0;
  int taken_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit idle_on = 1'b1;
  int cycle_count = 0;

  sorted_priority_queue_unit #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(32),
    .PRIO_BITS (16)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp_data)
  );

  // 8 unit clock period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // applies one request to the predicted row and returns the response it owes
  function automatic spq_pkg::rsp_t queue_step(input spq_pkg::req_t r);
    spq_pkg::rsp_t res;
    int unsigned pos;
    res = '0;
    res.error_code = spq_pkg::ERR_OK;
    if (r.req_type == spq_pkg::REQ_ENQUEUE) begin
      n_enq++;
      if (held >= CAPACITY) begin
        // full: entry dropped, row untouched
        res.error_code = spq_pkg::ERR_FULL;
        n_full++;
      end else begin
        // new entry goes ahead of every entry of equal priority
        pos = 0;
        while (pos < held && slot_pri[pos] < r.new_priority) pos++;
        for (int unsigned i = held; i > pos; i--) begin
          slot_val[i] = slot_val[i - 1];
          slot_pri[i] = slot_pri[i - 1];
        end
        slot_val[pos] = r.new_value;
        slot_pri[pos] = r.new_priority;
        held++;
      end
    end else begin
      n_deq++;
      if (held == 0) begin
        res.error_code = spq_pkg::ERR_EMPTY;
        n_empty++;
      end else begin
        for (int unsigned i = 1; i < held; i++) begin
          slot_val[i - 1] = slot_val[i];
          slot_pri[i - 1] = slot_pri[i];
        end
        held--;
      end
    end
    // empty row reports a zero front
    if (held == 0) begin
      res.is_empty = 1'b1;
    end else begin
      res.front_value    = slot_val[0];
      res.front_priority = slot_pri[0];
    end
    res.count = held[4:0];
    return res;
  endfunction

  task automatic check_rsp(input spq_pkg::rsp_t got, input spq_pkg::rsp_t want);
    bit bad;
    bad = (got.front_value !== want.front_value) ||
          (got.front_priority !== want.front_priority) ||
          (got.count !== want.count) ||
          (got.is_empty !== want.is_empty) ||
          (got.error_code !== want.error_code);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch on response %0d (expected / actual):", rsp_seen);
        $display("  front_value %h / %h  front_priority %h / %h",
                 want.front_value, got.front_value,
                 want.front_priority, got.front_priority);
        $display("  count %0d / %0d  is_empty %b / %b  error_code %0d / %0d",
                 want.count, got.count, want.is_empty, got.is_empty,
                 want.error_code, got.error_code);
      end
    end
  endtask

  // monitor: responses are checked before the request taken at the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("response %0d arrived with none expected: %h", rsp_seen, rsp_data);
          end
        end else begin
          check_rsp(rsp_data, expected_rsps.pop_front());
        end
      end
      if (req_valid && req_ready) begin
        expected_rsps.push_back(queue_step(req_data));
        taken_count++;
      end
    end
  end

  // request driver: holds the offered request until taken, then idles or offers the next
  always @(negedge clk) begin
    if (!rst && !(req_valid && taken_count != offered_count)) begin
      if (pending_reqs.size() == 0 || gap_left > 0 ||
          (offered_count == DRAIN_AT && expected_rsps.size() != 0)) begin
        // out of requests, in an idle burst, or pausing until the block has drained
        if (gap_left > 0) gap_left--;
        req_valid <= 1'b0;
      end else begin
        req_data  <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        offered_count++;
        // idling switches on and off in stretches, and stops for the tail
        if (offered_count % 128 == 0) idle_on = ($urandom_range(0, 3) != 0);
        if (pending_reqs.size() < QUIET_TAIL) idle_on = 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 16);
      end
    end
  end

  // response ready: one long hold partway through, and random stall bursts
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && taken_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic void add_req(input logic kind, input logic [31:0] v,
                                  input logic [15:0] p);
    spq_pkg::req_t r;
    r.req_type     = kind;
    r.new_value    = v;
    r.new_priority = p;
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // priorities crowd into a few small values so ties are common
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 16'($urandom_range(0, 7));
      4: return 16'h0000;
      5: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin : stimulus
    int seg_len;
    int enq_pct;
    logic kind;
    // directed: dequeue on empty, extreme values, ties, fill to full and overflow
    add_req(spq_pkg::REQ_DEQUEUE, 32'h0000_0000, 16'h0000);
    add_req(spq_pkg::REQ_ENQUEUE, 32'hffff_ffff, 16'hffff);
    add_req(spq_pkg::REQ_ENQUEUE, 32'h0000_0000, 16'h0000);
    add_req(spq_pkg::REQ_ENQUEUE, 32'h5a5a_5a5a, 16'h0000);  // tie goes to the front
    add_req(spq_pkg::REQ_ENQUEUE, 32'ha5a5_a5a5, 16'h8000);
    add_req(spq_pkg::REQ_DEQUEUE, 32'hffff_ffff, 16'hffff);
    add_req(spq_pkg::REQ_DEQUEUE, 32'h1234_5678, 16'h8000);
    for (int k = 0; k < 14; k++) begin
      add_req(spq_pkg::REQ_ENQUEUE, 32'h1000_0000 + k,
              (k % 3 == 0) ? 16'h8000 : 16'(16'h0100 * (k % 5)));
    end
    add_req(spq_pkg::REQ_ENQUEUE, 32'hdead_beef, 16'h0000);  // full, dropped
    repeat (3) add_req(spq_pkg::REQ_DEQUEUE, $urandom, 16'($urandom_range(0, 65535)));

    // random: segments lean toward filling, churning or draining
    while (pending_reqs.size() < ITEM_TARGET) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 50;
        default: enq_pct = 15;
      endcase
      repeat (seg_len) begin
        kind = ($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQUEUE
                                                 : spq_pkg::REQ_DEQUEUE;
        add_req(kind, pick_value(), pick_priority());
      end
    end

    while (pending_reqs.size() != 0 || taken_count != offered_count ||
           expected_rsps.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests: %0d enqueues (%0d dropped while full),",
             offered_count, n_enq, n_full);
    $display("%0d dequeues (%0d on empty), %0d responses checked, %0d mismatches",
             n_deq, n_empty, rsp_seen, mismatch_count);
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d responses still owed", cycle_count,
             expected_rsps.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
